// File: rtl/linear_probe_hash_table_defines.svh
// assertion macros shared by the checker
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht check failed");

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht check failed");

`endif

// File: rtl/lpht_pkg.sv
package lpht_pkg;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 7;
    localparam int MARK_W   = 2;

    localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

    // modulo unit retires this many product bits per cycle
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = KEY_W / MOD_DIGIT_W;
    localparam int MOD_STEP_W  = $clog2(MOD_STEPS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LOOKUP = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY    = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_DELETED  = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MOD,
        S_START,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    mul;
        logic    mod_step;
        logic    start;
        logic    read;
        logic    advance;
        logic    wr_new;
        logic    wr_upd;
        logic    wr_del;
        logic    take_value;
        logic    set_res;
        status_t res_status;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic              clr_last;
        logic              mod_last;
        logic [FUNC_W-1:0] func;
        logic              count_zero;
        logic              mark_empty;
        logic              key_match;
        logic              free_avail;
        logic              last_probe;
        logic              out_free;
    } stat_t;

endpackage

// File: rtl/lpht_if.sv
interface lpht_req_if;
    logic                         valid;
    logic                         ready;
    logic [lpht_pkg::FUNC_W-1:0]  func;
    logic [lpht_pkg::KEY_W-1:0]   key;
    logic [lpht_pkg::VALUE_W-1:0] payload;

    modport source (output valid, func, key, payload, input ready);
    modport sink (input valid, func, key, payload, output ready);
endinterface

interface lpht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::STATUS_W-1:0] status;
    logic [lpht_pkg::VALUE_W-1:0]  found_value;
    logic [lpht_pkg::LIVE_W-1:0]   live_count;

    modport source (output valid, status, found_value, live_count, input ready);
    modport sink (input valid, status, found_value, live_count, output ready);
endinterface

// File: rtl/linear_probe_hash_table.sv
// Open-addressing hash table of SLOTS entries, 32-bit key to 32-bit value, with
// linear probing and tombstones. After reset the block sweeps the slot marks to
// empty, one slot a cycle, with req.ready held low until the sweep ends. It then
// takes one request at a time: insert/update, remove or lookup, each giving one
// response on rsp. After acceptance a request passes through the hash multiply,
// the modulo-SLOTS unit (4 product bits per step) and dispatch, then probes at
// most SLOTS slots; remove or lookup on an empty table and the unused function
// code skip the probes. Each probe is a read of the slot memories followed by a
// compare. A finished response waits in the output register, and a new request
// is accepted while it is still pending.
module linear_probe_hash_table #(
    parameter int SLOTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp
);

    // command and status between sequencer and datapath
    lpht_pkg::cmd_t  cmd;
    lpht_pkg::stat_t stat;
    logic            ready;

    // sequencer: clearing sweep, hash, modulo, probe loop, response hand-off
    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    assign req.ready = ready;

    // datapath: request latch, hash unit, slot memories, count and output register
    lpht_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_func    (req.func),
        .req_key     (req.key),
        .req_payload (req.payload),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_status  (rsp.status),
        .rsp_value   (rsp.found_value),
        .rsp_live    (rsp.live_count)
    );

endmodule

// File: rtl/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lpht_ctrl.sv
module lpht_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  lpht_pkg::stat_t  stat,
    output lpht_pkg::cmd_t   cmd
);

    lpht_pkg::state_t state_reg;
    lpht_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpht_pkg::S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lpht_pkg::S_MUL;
                end
            end
            lpht_pkg::S_MUL:
            begin
                state_next = lpht_pkg::S_MOD;
            end
            lpht_pkg::S_MOD:
            begin
                if (stat.mod_last)
                begin
                    state_next = lpht_pkg::S_START;
                end
            end
            lpht_pkg::S_START:
            begin
                case (stat.func)
                    lpht_pkg::FUNC_INSERT:
                    begin
                        state_next = lpht_pkg::S_READ;
                    end
                    lpht_pkg::FUNC_REMOVE, lpht_pkg::FUNC_LOOKUP:
                    begin
                        state_next = stat.count_zero ? lpht_pkg::S_FINISH : lpht_pkg::S_READ;
                    end
                    default:
                    begin
                        state_next = lpht_pkg::S_FINISH;
                    end
                endcase
            end
            lpht_pkg::S_READ:
            begin
                state_next = lpht_pkg::S_EVAL;
            end
            lpht_pkg::S_EVAL:
            begin
                if (stat.mark_empty || stat.key_match || stat.last_probe)
                begin
                    state_next = lpht_pkg::S_FINISH;
                end
                else
                begin
                    state_next = lpht_pkg::S_READ;
                end
            end
            lpht_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            lpht_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            lpht_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            lpht_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            lpht_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            lpht_pkg::S_START:
            begin
                cmd.start = 1'b1;
                if ((stat.func inside {lpht_pkg::FUNC_REMOVE, lpht_pkg::FUNC_LOOKUP})
                    && stat.count_zero)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = lpht_pkg::ST_EMPTY;
                end
            end
            lpht_pkg::S_READ:
            begin
                cmd.read = 1'b1;
            end
            lpht_pkg::S_EVAL:
            begin
                case (stat.func)
                    lpht_pkg::FUNC_INSERT:
                    begin
                        if (stat.key_match)
                        begin
                            cmd.wr_upd = 1'b1;
                        end
                        else if (stat.mark_empty)
                        begin
                            cmd.wr_new = 1'b1;
                        end
                        else if (stat.last_probe)
                        begin
                            if (stat.free_avail)
                            begin
                                cmd.wr_new = 1'b1;
                            end
                            else
                            begin
                                cmd.set_res    = 1'b1;
                                cmd.res_status = lpht_pkg::ST_FULL;
                            end
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                    lpht_pkg::FUNC_REMOVE, lpht_pkg::FUNC_LOOKUP:
                    begin
                        if (stat.key_match)
                        begin
                            cmd.wr_del     = (stat.func == lpht_pkg::FUNC_REMOVE);
                            cmd.take_value = (stat.func == lpht_pkg::FUNC_LOOKUP);
                        end
                        else if (stat.mark_empty || stat.last_probe)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = lpht_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = lpht_pkg::ST_OK;
                    end
                endcase
            end
            lpht_pkg::S_FINISH:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/lpht_dp.sv
module lpht_dp #(
    parameter int SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lpht_pkg::FUNC_W-1:0]   req_func,
    input  logic [lpht_pkg::KEY_W-1:0]    req_key,
    input  logic [lpht_pkg::VALUE_W-1:0]  req_payload,
    input  lpht_pkg::cmd_t                cmd,
    output lpht_pkg::stat_t               stat,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
    output logic [lpht_pkg::VALUE_W-1:0]  rsp_value,
    output logic [lpht_pkg::LIVE_W-1:0]   rsp_live
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DATA_W = lpht_pkg::KEY_W + lpht_pkg::VALUE_W;

    localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

    logic [lpht_pkg::FUNC_W-1:0]  func_reg;
    logic [lpht_pkg::KEY_W-1:0]   key_reg;
    logic [lpht_pkg::VALUE_W-1:0] payload_reg;
    logic [lpht_pkg::KEY_W-1:0]   prod_reg;
    logic [IDX_W-1:0]             rem_reg;
    logic [IDX_W-1:0]             rem_next;
    logic [IDX_W-1:0]             rem_work;
    logic [IDX_W:0]               trial;
    logic [lpht_pkg::MOD_STEP_W-1:0] step_reg;

    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             idx_next;
    logic [IDX_W-1:0]             probe_reg;
    logic [IDX_W-1:0]             tomb_reg;
    logic                         have_tomb_reg;
    logic [IDX_W-1:0]             target;
    logic [CNT_W-1:0]             count_reg;
    logic [IDX_W-1:0]             clr_reg;

    lpht_pkg::status_t            res_status_reg;
    logic [lpht_pkg::VALUE_W-1:0] res_value_reg;

    logic                         rsp_valid_reg;
    lpht_pkg::status_t            rsp_status_reg;
    logic [lpht_pkg::VALUE_W-1:0] rsp_value_reg;
    logic [lpht_pkg::LIVE_W-1:0]  rsp_live_reg;

    logic                         data_we;
    logic [IDX_W-1:0]             data_waddr;
    logic [DATA_W-1:0]            data_rdata;
    logic                         mark_we;
    logic [IDX_W-1:0]             mark_waddr;
    logic [lpht_pkg::MARK_W-1:0]  mark_wdata;
    logic [lpht_pkg::MARK_W-1:0]  mark_rdata;
    logic [lpht_pkg::KEY_W-1:0]   rd_key;
    logic [lpht_pkg::VALUE_W-1:0] rd_value;
    logic                         out_free;

    // restoring remainder, several product bits a cycle, msb first
    always_comb
    begin
        rem_work = rem_reg;
        trial    = '0;
        for (int b = 0; b < lpht_pkg::MOD_DIGIT_W; b++)
        begin
            trial = {rem_work, prod_reg[lpht_pkg::KEY_W-1-b]};
            if (trial >= SLOTS_EXT)
            begin
                trial = trial - SLOTS_EXT;
            end
            rem_work = trial[IDX_W-1:0];
        end
        rem_next = rem_work;
    end

    assign idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign target   = have_tomb_reg ? tomb_reg : idx_reg;
    assign rd_key   = data_rdata[DATA_W-1 -: lpht_pkg::KEY_W];
    assign rd_value = data_rdata[lpht_pkg::VALUE_W-1:0];
    assign out_free = !rsp_valid_reg || rsp_ready;

    // slot key/value store
    assign data_we    = cmd.wr_new || cmd.wr_upd;
    assign data_waddr = cmd.wr_new ? target : idx_reg;

    lpht_ram #(
        .WIDTH(DATA_W),
        .DEPTH(SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata ({key_reg, payload_reg}),
        .re    (cmd.read),
        .raddr (idx_reg),
        .rdata (data_rdata)
    );

    // slot marks, swept to empty after reset
    always_comb
    begin
        mark_we    = cmd.clr_step || cmd.wr_new || cmd.wr_del;
        mark_waddr = idx_reg;
        mark_wdata = lpht_pkg::MARK_DELETED;
        if (cmd.clr_step)
        begin
            mark_waddr = clr_reg;
            mark_wdata = lpht_pkg::MARK_EMPTY;
        end
        else if (cmd.wr_new)
        begin
            mark_waddr = target;
            mark_wdata = lpht_pkg::MARK_OCCUPIED;
        end
    end

    lpht_ram #(
        .WIDTH(lpht_pkg::MARK_W),
        .DEPTH(SLOTS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.read),
        .raddr (idx_reg),
        .rdata (mark_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            step_reg      <= '0;
            probe_reg     <= '0;
            have_tomb_reg <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.mul)
            begin
                step_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.start)
            begin
                probe_reg     <= '0;
                have_tomb_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                probe_reg <= probe_reg + 1'b1;
                if (mark_rdata == lpht_pkg::MARK_DELETED)
                begin
                    have_tomb_reg <= 1'b1;
                end
            end
            if (cmd.wr_new)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.wr_del)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg       <= req_func;
            key_reg        <= req_key;
            payload_reg    <= req_payload;
            res_status_reg <= lpht_pkg::ST_OK;
            res_value_reg  <= '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= key_reg * lpht_pkg::HASH_MULT;
            rem_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            prod_reg <= prod_reg << lpht_pkg::MOD_DIGIT_W;
            rem_reg  <= rem_next;
        end
        if (cmd.start)
        begin
            idx_reg <= rem_reg;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_next;
            if (!have_tomb_reg && (mark_rdata == lpht_pkg::MARK_DELETED))
            begin
                tomb_reg <= idx_reg;
            end
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
        end
        if (cmd.take_value)
        begin
            res_value_reg <= rd_value;
        end
        if (cmd.emit)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_value_reg  <= res_value_reg;
            rsp_live_reg   <= lpht_pkg::LIVE_W'(count_reg);
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.clr_last   = (clr_reg == LAST_IDX);
        stat.mod_last   = (step_reg == lpht_pkg::MOD_STEP_W'(lpht_pkg::MOD_STEPS - 1));
        stat.func       = func_reg;
        stat.count_zero = (count_reg == '0);
        stat.mark_empty = (mark_rdata == lpht_pkg::MARK_EMPTY);
        stat.key_match  = (mark_rdata == lpht_pkg::MARK_OCCUPIED) && (rd_key == key_reg);
        stat.free_avail = have_tomb_reg || (mark_rdata == lpht_pkg::MARK_DELETED);
        stat.last_probe = (probe_reg == LAST_IDX);
        stat.out_free   = out_free;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_value  = rsp_value_reg;
    assign rsp_live   = rsp_live_reg;

endmodule

// File: rtl/lpht_checker.sv
`include "linear_probe_hash_table_defines.svh"

module lpht_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [lpht_pkg::STATUS_W-1:0] status,
    input logic [lpht_pkg::VALUE_W-1:0]  found_value,
    input logic [lpht_pkg::LIVE_W-1:0]   live_count
);

    // stalled response holds
    `LPHT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(found_value) && $stable(live_count))

    // one request in flight at a time
    `LPHT_ASSERT_NEXT(a_one_request, clk, rst_n, req_valid && req_ready, !req_ready)

    // a value only comes back with a good status
    `LPHT_ASSERT_SAME(a_value_on_ok, clk, rst_n, rsp_valid && (found_value != '0), status == lpht_pkg::ST_OK)

    // empty status means nothing is live
    `LPHT_ASSERT_SAME(a_empty_count, clk, rst_n, rsp_valid && (status == lpht_pkg::ST_EMPTY), live_count == '0)

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .found_value (rsp.found_value),
    .live_count  (rsp.live_count)
);

// File: bench/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int SLOTS     = 64;
    localparam int SLOT_BITS = $clog2(SLOTS);

    // func code the block leaves unused: no change, status ok, value zero
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS  = 1800;
    localparam int POOL_SIZE    = 96;
    // cycles with no handshake on either side before the run is abandoned
    localparam int STALL_LIMIT  = 5000;
    // settle time covers one more request in flight, even one that probes every slot
    localparam int SETTLE_CYCLES = 200;
    localparam int REPORT_CAP   = 100;

    // one predicted response
    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   value;
        logic [LIVE_W-1:0]    live;
    } table_response_t;

    // shadow of the table: predicts each response and holds the ones still due
    class hash_table_scoreboard;
        logic [KEY_W-1:0]   keys   [SLOTS];
        logic [VALUE_W-1:0] values [SLOTS];
        mark_t              marks  [SLOTS];
        int                 live_total;
        table_response_t    expected_responses [$];
        int                 mismatches;
        int                 responses_seen;

        function new();
            for (int i = 0; i < SLOTS; i++)
                marks[i] = MARK_EMPTY;
            live_total     = 0;
            mismatches     = 0;
            responses_seen = 0;
        endfunction

        // slots is a power of two, so the modulo is the low product bits
        static function int home_slot(logic [KEY_W-1:0] key);
            logic [KEY_W-1:0] product;
            product = key * HASH_MULT;
            return int'(product[SLOT_BITS-1:0]);
        endfunction

        // slot holding key, or -1 when absent
        function int find_slot(logic [KEY_W-1:0] key);
            int slot;
            slot = home_slot(key);
            for (int p = 0; p < SLOTS; p++) begin
                if (marks[slot] == MARK_EMPTY)
                    return -1;
                if (marks[slot] == MARK_OCCUPIED && keys[slot] == key)
                    return slot;
                slot = (slot + 1) % SLOTS;
            end
            return -1;
        endfunction

        function status_t apply_insert(logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
            int slot;
            int tomb;
            int target;
            slot   = home_slot(key);
            tomb   = -1;
            target = -1;
            for (int p = 0; p < SLOTS; p++) begin
                if (marks[slot] == MARK_EMPTY) begin
                    target = (tomb >= 0) ? tomb : slot;
                    break;
                end
                if (marks[slot] == MARK_DELETED) begin
                    if (tomb < 0)
                        tomb = slot;
                end else if (keys[slot] == key) begin
                    values[slot] = value;
                    return ST_OK;
                end
                slot = (slot + 1) % SLOTS;
            end
            if (target < 0) begin
                if (tomb < 0)
                    return ST_FULL;
                target = tomb;
            end
            keys[target]   = key;
            values[target] = value;
            marks[target]  = MARK_OCCUPIED;
            live_total++;
            return ST_OK;
        endfunction

        function void predict_response(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                                       logic [VALUE_W-1:0] payload);
            table_response_t rsp;
            int              slot;
            rsp.status = ST_OK;
            rsp.value  = '0;
            case (func)
                FUNC_INSERT: rsp.status = apply_insert(key, payload);
                FUNC_REMOVE, FUNC_LOOKUP:
                begin
                    if (live_total == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        slot = find_slot(key);
                        if (slot < 0) begin
                            rsp.status = ST_NOT_FOUND;
                        end else if (func == FUNC_REMOVE) begin
                            marks[slot] = MARK_DELETED;
                            live_total--;
                        end else begin
                            rsp.value = values[slot];
                        end
                    end
                end
                default: ;
            endcase
            rsp.live = LIVE_W'(live_total);
            expected_responses.push_back(rsp);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("mismatch at response %0d: %s", responses_seen, what);
        endtask

        task check_response(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                            logic [LIVE_W-1:0] live);
            table_response_t want;
            if (expected_responses.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = expected_responses.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (value !== want.value)
                    report_mismatch($sformatf("found_value %h, want %h", value, want.value));
                if (live !== want.live)
                    report_mismatch($sformatf("live_count %0d, want %0d", live, want.live));
            end
            responses_seen++;
        endtask

        function int pending();
            return expected_responses.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lpht_req_if req_bus ();
    lpht_rsp_if rsp_bus ();

    linear_probe_hash_table #(
        .SLOTS (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    hash_table_scoreboard sb = new();

    // idling odds in percent, switched by phase of the run
    int req_idle_pct = 28;
    int rsp_idle_pct = 73;
    int sent_count   = 0;
    int stall_cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // every input known from time zero
    initial
    begin
        req_bus.valid   = 1'b0;
        req_bus.func    = FUNC_INSERT;
        req_bus.key     = '0;
        req_bus.payload = '0;
        rsp_bus.ready   = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
        rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);

    // accepted request: predict its response
    always @(posedge clk)
        if (rst_n && req_bus.valid && req_bus.ready)
            sb.predict_response(req_bus.func, req_bus.key, req_bus.payload);

    // accepted response: compare with the oldest prediction
    always @(posedge clk)
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.status, rsp_bus.found_value, rsp_bus.live_count);

    // watchdog on cycles with no handshake at all
    initial
    begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // sender idles 28 / receiver 73, then the other way round, then no idling
    function automatic void set_pressure();
        if (sent_count < TOTAL_ITEMS / 3) begin
            req_idle_pct = 28;
            rsp_idle_pct = 73;
        end else if (sent_count < 2 * TOTAL_ITEMS / 3) begin
            req_idle_pct = 73;
            rsp_idle_pct = 28;
        end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                                logic [VALUE_W-1:0] payload);
        set_pressure();
        while ($urandom_range(99) < req_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.func    <= func;
        req_bus.key     <= key;
        req_bus.payload <= payload;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // home slot depends only on the low key bits, so keep the noise above them
    function automatic logic [KEY_W-1:0] key_at_home(int home, logic [KEY_W-1:0] noise);
        logic [KEY_W-1:0] key;
        key = noise;
        for (int j = 0; j < SLOTS; j++) begin
            key[SLOT_BITS-1:0] = SLOT_BITS'(j);
            if (hash_table_scoreboard::home_slot(key) == home)
                return key;
        end
        return key;
    endfunction

    // fresh key set: either spread over the table or bunched into a few homes
    // so that probe runs get long and wrap past the last slot
    task automatic refill_pool();
        int bunched;
        int base;
        int home;
        bunched = $urandom_range(1);
        base    = $urandom_range(SLOTS - 1);
        for (int i = 0; i < POOL_SIZE; i++) begin
            home = bunched ? (base + $urandom_range(7)) % SLOTS : $urandom_range(SLOTS - 1);
            key_pool[i] = key_at_home(home, $urandom());
        end
    endtask

    function automatic logic [KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // mostly known keys, some never inserted to hit the missing-key path
    function automatic logic [KEY_W-1:0] probe_key();
        if ($urandom_range(99) < 85)
            return pool_key();
        return $urandom();
    endfunction

    // inserts always use pool keys so that a drain sweep empties the table
    task automatic random_request(int ins_pct, int rem_pct, int look_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < ins_pct)
            send_request(FUNC_INSERT, pool_key(), $urandom());
        else if (pick < ins_pct + rem_pct)
            send_request(FUNC_REMOVE, probe_key(), $urandom());
        else if (pick < ins_pct + rem_pct + look_pct)
            send_request(FUNC_LOOKUP, probe_key(), $urandom());
        else
            send_request(FUNC_UNUSED, $urandom(), $urandom());
    endtask

    task automatic directed_requests();
        logic [KEY_W-1:0] wrap_a;
        logic [KEY_W-1:0] wrap_b;
        logic [KEY_W-1:0] wrap_c;
        logic [KEY_W-1:0] wrap_d;
        // chain on the last slot, wrapping round past slot 0
        wrap_a = key_at_home(SLOTS - 1, 32'h0000_0040);
        wrap_b = key_at_home(SLOTS - 1, 32'h8000_0080);
        wrap_c = key_at_home(SLOTS - 1, 32'h5555_5500);
        wrap_d = key_at_home(SLOTS - 1, 32'hAAAA_AA00);

        // remove and lookup on the empty table
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // unused code changes nothing
        send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // extreme keys and values
        send_request(FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // update in place
        send_request(FUNC_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        // missing key
        send_request(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        // collisions with wraparound
        send_request(FUNC_INSERT, wrap_a, 32'hA5A5_A5A5);
        send_request(FUNC_INSERT, wrap_b, 32'h5A5A_5A5A);
        send_request(FUNC_INSERT, wrap_c, 32'h0F0F_0F0F);
        // tombstone in the middle of the run, then look past it
        send_request(FUNC_REMOVE, wrap_b, 32'h0000_0000);
        send_request(FUNC_LOOKUP, wrap_c, 32'h0000_0000);
        send_request(FUNC_REMOVE, wrap_b, 32'h0000_0000);
        send_request(FUNC_LOOKUP, wrap_b, 32'h0000_0000);
        // new key reuses the tombstone
        send_request(FUNC_INSERT, wrap_d, 32'hF0F0_F0F0);
        send_request(FUNC_LOOKUP, wrap_d, 32'h0000_0000);
        send_request(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_UNUSED, 32'h0000_0000, 32'h0000_0000);
        // clear the rest so the random part starts from an empty table
        send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_REMOVE, wrap_a, 32'h0000_0000);
        send_request(FUNC_REMOVE, wrap_c, 32'h0000_0000);
        send_request(FUNC_REMOVE, wrap_d, 32'h0000_0000);
    endtask

    // fill to full, churn with tombstones, then sweep the pool out again
    task automatic random_requests();
        while (sent_count < TOTAL_ITEMS) begin
            refill_pool();
            // filling: reaches a full table and the full status
            for (int i = 0; i < 160; i++)
                random_request(80, 5, 12);
            // churn: tombstones fill up, lookups wrap the whole table
            for (int i = 0; i < 100; i++)
                random_request(35, 30, 32);
            // drain: every pool key removed, with lookups mixed in
            for (int i = 0; i < POOL_SIZE; i++) begin
                send_request(FUNC_REMOVE, key_pool[i], $urandom());
                if ($urandom_range(99) < 30)
                    send_request(FUNC_LOOKUP, probe_key(), $urandom());
            end
            // table is empty now
            for (int i = 0; i < 4; i++)
                random_request(0, 50, 50);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_requests();
        random_requests();
        req_bus.valid <= 1'b0;

        // let every predicted response arrive, then watch for strays
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
